[src/assert_macros.svh]
// Assertion shorthands; each expects clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, held off during reset.
`define TSW_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Same-cycle implication.
`define TSW_ASSERT_IMP(label, cond, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error(msg);

`endif

[src/tsw_pkg.sv]
package tsw_pkg;

   localparam int MAX_PAYLOAD_DEF  = 1452;
   localparam int FLIGHT_DEPTH_DEF = 32;
   localparam int MAX_RESULTS      = 47;
   localparam int K_W              = $clog2(MAX_RESULTS + 1);
   localparam int ALU_W            = 64;
   localparam int SEQ_W            = 32;
   localparam int CSR_IDX_W        = 1;
   localparam int CSR_DATA_W       = 32;
   localparam int TIMEOUT_W        = 16;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd1000;

   localparam logic [CSR_IDX_W-1:0] CSR_ISN     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 1'd1;

   typedef enum logic [1:0] {
      KIND_FILL  = 2'd0,
      KIND_ACK   = 2'd1,
      KIND_TICK  = 2'd2,
      KIND_EMPTY = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      RES_NONE  = 2'd0,
      RES_NEW   = 2'd1,
      RES_RETX  = 2'd2,
      RES_EMPTY = 2'd3
   } res_kind_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] buffered_bytes;
      logic        input_ended;
      logic [31:0] ack_number;
      logic [15:0] advertised_window;
      logic [15:0] elapsed_ms;
   } req_type;

   typedef struct packed {
      res_kind_type result_kind;
      logic [31:0]  segment_seqno;
      logic [10:0]  payload_length;
      logic         syn_flag;
      logic         fin_flag;
      logic [7:0]   retransmit_count;
      logic         last_result;
   } rsp_type;

endpackage

[src/tsw_chan_if.sv]
interface tsw_chan_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

[src/tsw_alu.sv]
// Shared 64-bit add/subtract; carry out doubles as "no borrow" on subtract.
module tsw_alu import tsw_pkg::*; (
   input  logic [ALU_W-1:0] op_a,
   input  logic [ALU_W-1:0] op_b,
   input  logic             sub,
   output logic [ALU_W-1:0] sum,
   output logic             carry
);
   assign {carry, sum} = {1'b0, op_a} + {1'b0, op_b ^ {ALU_W{sub}}} + (ALU_W + 1)'(sub);
endmodule

[src/tcp_sender_window_retransmit.sv]
// TCP sender control. Items on req_chan are fills, acks, timer ticks or
// empty-segment requests; each one produces one or more rsp_chan items, the
// last marked by last_result. A fill cuts the sender window into segment
// descriptors (SYN, payloads up to MAX_PAYLOAD bytes, FIN), queues each in
// the flight FIFO and returns it; an ack updates the windows and pops every
// fully acknowledged descriptor; a tick runs the retransmission timer and
// resends the oldest descriptor on expiry, doubling the timeout while the
// receiver window is open. All wide math goes through one 64-bit adder
// stepped by a sequencer, so req_chan is held off while an item is in work,
// including any rsp_chan stall. Finished items sit in an output register,
// so the next request is taken while the last result waits.
// Configuration writes (csr_*) are expected only while the block is idle.
`include "assert_macros.svh"

module tcp_sender_window_retransmit import tsw_pkg::*; #(
   parameter int MAX_PAYLOAD  = MAX_PAYLOAD_DEF,
   parameter int FLIGHT_DEPTH = FLIGHT_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   tsw_chan_if.sink              req_chan,
   tsw_chan_if.source            rsp_chan,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);
   localparam int PL_W  = $clog2(MAX_PAYLOAD + 2);   // chunk holds MAX_PAYLOAD + SYN
   localparam int IDX_W = $clog2(FLIGHT_DEPTH);
   localparam int CNT_W = $clog2(FLIGHT_DEPTH + 1);
   localparam int SUM_W = IDX_W + 1;
   localparam int ENT_W = SEQ_W + PL_W + 2;

   typedef enum logic [17:0] {
      ST_IDLE = 18'h00001,
      ST_FCHK = 18'h00002,
      ST_FSEQ = 18'h00004,
      ST_FSW  = 18'h00008,
      ST_FCOM = 18'h00010,
      ST_UW1  = 18'h00020,
      ST_UW2  = 18'h00040,
      ST_UW3  = 18'h00080,
      ST_ACMP = 18'h00100,
      ST_AWIN = 18'h00200,
      ST_PRD  = 18'h00400,
      ST_PEND = 18'h00800,
      ST_PCMP = 18'h01000,
      ST_TADD = 18'h02000,
      ST_TCMP = 18'h04000,
      ST_TRD  = 18'h08000,
      ST_TRTX = 18'h10000,
      ST_DONE = 18'h20000
   } state_type;

   // control state
   state_type            state_ff, state_in;
   logic [31:0]          isn_ff, isn_in;
   logic [TIMEOUT_W-1:0] init_to_ff, init_to_in;
   logic [63:0]          next_ff, next_in;
   logic [31:0]          swnd_ff, swnd_in;
   logic [15:0]          rwnd_ff, rwnd_in;
   logic                 fin_sent_ff, fin_sent_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 run_ff, run_in;
   logic [31:0]          elap_ff, elap_in;
   logic [31:0]          cto_ff, cto_in;
   logic [7:0]           rcnt_ff, rcnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 pend_v_ff, pend_v_in;

   // working registers
   req_kind_type         kind_ff, kind_in;
   logic [15:0]          avail_ff, avail_in;
   logic                 ended_ff, ended_in;
   logic [31:0]          ackn_ff, ackn_in;
   logic [15:0]          advw_ff, advw_in;
   logic [15:0]          ms_ff, ms_in;
   logic [31:0]          rem_ff, rem_in;
   logic [PL_W-1:0]      chunk_ff, chunk_in;
   logic                 last_chunk_ff, last_chunk_in;
   logic                 syn_ff, syn_in;
   logic [PL_W-1:0]      len_ff, len_in;
   logic [31:0]          seq_ff, seq_in;
   logic [31:0]          swn_ff, swn_in;
   logic                 fin_ff, fin_in;
   logic [K_W-1:0]       k_ff, k_in;
   logic                 popped_ff, popped_in;
   logic                 uw_src_ff, uw_src_in;     // 0 ack number, 1 queue head
   logic [63:0]          c_ff, c_in;
   logic                 adj_inc_ff, adj_inc_in;
   logic                 adj_dec_ff, adj_dec_in;
   logic [63:0]          ackabs_ff, ackabs_in;
   logic [63:0]          d_ff, d_in;
   logic [63:0]          start_ff, start_in;
   rsp_type              pend_ff, pend_in;
   rsp_type              rsp_ff, rsp_in;

   // flight queue
   logic [ENT_W-1:0]     mem [FLIGHT_DEPTH];
   logic [ENT_W-1:0]     rd_ff;
   logic                 mem_we;
   logic [ENT_W-1:0]     mem_wdata;
   logic [IDX_W-1:0]     tail;
   logic [SUM_W-1:0]     tail_sum;
   logic [IDX_W-1:0]     head_nx;

   logic [31:0]          rd_seq;
   logic [PL_W-1:0]      rd_len;
   logic                 rd_syn;
   logic                 rd_fin;

   // shared adder
   logic [ALU_W-1:0]     alu_a, alu_b, alu_res;
   logic                 alu_sub, alu_carry, alu_borrow;

   logic                 out_free;
   logic                 next_zero;
   logic                 cnt_full;
   logic                 fcom_go;

   assign rd_seq = rd_ff[ENT_W-1 -: SEQ_W];
   assign rd_len = rd_ff[2 +: PL_W];
   assign rd_syn = rd_ff[1];
   assign rd_fin = rd_ff[0];

   assign out_free   = !rsp_valid_ff || rsp_chan.ready;
   assign next_zero  = (next_ff == '0);
   assign cnt_full   = (cnt_ff == CNT_W'(FLIGHT_DEPTH));
   assign fcom_go    = !pend_v_ff || out_free;
   assign alu_borrow = !alu_carry;

   assign tail_sum = SUM_W'(head_ff) + SUM_W'(cnt_ff);
   assign tail     = (tail_sum >= SUM_W'(FLIGHT_DEPTH)) ?
                     IDX_W'(tail_sum - SUM_W'(FLIGHT_DEPTH)) : IDX_W'(tail_sum);
   assign head_nx  = (head_ff == IDX_W'(FLIGHT_DEPTH - 1)) ? '0 : head_ff + 1'b1;

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   tsw_alu u_alu (
      .op_a  (alu_a),
      .op_b  (alu_b),
      .sub   (alu_sub),
      .sum   (alu_res),
      .carry (alu_carry)
   );

   // operand select; default is wrapping next_abs_seqno
   always_comb begin
      alu_a   = next_ff;
      alu_b   = 64'(isn_ff);
      alu_sub = 1'b0;
      case (state_ff)
         ST_FSW: begin
            alu_a   = 64'(swnd_ff);
            alu_b   = 64'(syn_ff) + 64'(len_ff);
            alu_sub = 1'b1;
         end
         ST_FCOM: begin
            alu_b = 64'(syn_ff) + 64'(len_ff) + 64'(fin_ff);
         end
         ST_UW1: begin
            alu_a   = uw_src_ff ? 64'(rd_seq) : 64'(ackn_ff);
            alu_sub = 1'b1;
         end
         ST_UW2: begin
            alu_a   = c_ff;
            alu_b   = next_ff;
            alu_sub = 1'b1;
         end
         ST_UW3: begin
            alu_a   = c_ff;
            alu_b   = (adj_inc_ff || adj_dec_ff) ? 64'h1_0000_0000 : '0;
            alu_sub = adj_dec_ff;
         end
         ST_ACMP: begin
            alu_b   = ackabs_ff;
            alu_sub = 1'b1;
         end
         ST_AWIN: begin
            alu_a   = 64'(advw_ff) + 64'(advw_ff == '0);
            alu_b   = d_ff;
            alu_sub = 1'b1;
         end
         ST_PEND: begin
            alu_a = start_ff;
            alu_b = 64'(rd_syn) + 64'(rd_len) + 64'(rd_fin);
         end
         ST_PCMP: begin
            alu_a   = ackabs_ff;
            alu_b   = start_ff;
            alu_sub = 1'b1;
         end
         ST_TADD: begin
            alu_a = 64'(elap_ff);
            alu_b = 64'(ms_ff);
         end
         ST_TCMP: begin
            alu_a   = 64'(elap_ff);
            alu_b   = 64'(cto_ff);
            alu_sub = 1'b1;
         end
         default: ;
      endcase
   end

   // sequencer
   always_comb begin
      logic [PL_W-1:0] s;
      logic [31:0]     sw;
      logic            fin;
      logic [63:0]     t;
      logic            gtc;

      s  = '0;
      sw = '0;
      fin = 1'b0;
      t   = alu_res;
      gtc = 1'b0;

      state_in      = state_ff;
      isn_in        = isn_ff;
      init_to_in    = init_to_ff;
      next_in       = next_ff;
      swnd_in       = swnd_ff;
      rwnd_in       = rwnd_ff;
      fin_sent_in   = fin_sent_ff;
      head_in       = head_ff;
      cnt_in        = cnt_ff;
      run_in        = run_ff;
      elap_in       = elap_ff;
      cto_in        = cto_ff;
      rcnt_in       = rcnt_ff;
      rsp_valid_in  = rsp_valid_ff;
      pend_v_in     = pend_v_ff;
      kind_in       = kind_ff;
      avail_in      = avail_ff;
      ended_in      = ended_ff;
      ackn_in       = ackn_ff;
      advw_in       = advw_ff;
      ms_in         = ms_ff;
      rem_in        = rem_ff;
      chunk_in      = chunk_ff;
      last_chunk_in = last_chunk_ff;
      syn_in        = syn_ff;
      len_in        = len_ff;
      seq_in        = seq_ff;
      swn_in        = swn_ff;
      fin_in        = fin_ff;
      k_in          = k_ff;
      popped_in     = popped_ff;
      uw_src_in     = uw_src_ff;
      c_in          = c_ff;
      adj_inc_in    = adj_inc_ff;
      adj_dec_in    = adj_dec_ff;
      ackabs_in     = ackabs_ff;
      d_in          = d_ff;
      start_in      = start_ff;
      pend_in       = pend_ff;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_wdata     = {seq_ff, len_ff, syn_ff, fin_ff};

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_we) begin
         case (csr_index)
            CSR_ISN: begin
               isn_in = csr_data;
            end
            CSR_TIMEOUT: begin
               init_to_in = csr_data[TIMEOUT_W-1:0];
               cto_in     = 32'(csr_data[TIMEOUT_W-1:0]);
            end
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               kind_in  = req_kind_type'(req_chan.payload.kind);
               avail_in = req_chan.payload.buffered_bytes;
               ended_in = req_chan.payload.input_ended;
               ackn_in  = req_chan.payload.ack_number;
               advw_in  = req_chan.payload.advertised_window;
               ms_in    = req_chan.payload.elapsed_ms;
               case (req_kind_type'(req_chan.payload.kind))
                  KIND_FILL: begin
                     rem_in   = swnd_ff;
                     k_in     = '0;
                     state_in = ST_FCHK;
                  end
                  KIND_ACK: begin
                     uw_src_in = 1'b0;
                     state_in  = ST_UW1;
                  end
                  KIND_TICK: begin
                     state_in = run_ff ? ST_TADD : ST_DONE;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end

         // next window slice; any refusal to send is final for this fill
         ST_FCHK: begin
            if (fin_sent_ff || cnt_full || k_ff == K_W'(MAX_RESULTS) || rem_ff == '0) begin
               state_in = ST_DONE;
            end else if (rem_ff > 32'(MAX_PAYLOAD)) begin
               s             = PL_W'(MAX_PAYLOAD) + PL_W'(next_zero);
               chunk_in      = s;
               rem_in        = rem_ff - 32'(s);
               last_chunk_in = 1'b0;
               state_in      = ST_FSEQ;
            end else begin
               chunk_in      = PL_W'(rem_ff);
               rem_in        = '0;
               last_chunk_in = 1'b1;
               state_in      = ST_FSEQ;
            end
         end

         ST_FSEQ: begin
            seq_in = alu_res[31:0];
            syn_in = next_zero;
            if (next_zero) begin
               len_in = '0;
            end else if (32'(chunk_ff) < 32'(avail_ff)) begin
               len_in = chunk_ff;
            end else begin
               len_in = PL_W'(avail_ff);
            end
            if (!next_zero && avail_ff == '0 && !ended_ff) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_FSW;
            end
         end

         ST_FSW: begin
            sw  = alu_borrow ? '0 : alu_res[31:0];
            fin = ended_ff && (32'(avail_ff) == 32'(len_ff)) && (sw != '0);
            if (!syn_ff && len_ff == '0 && !fin) begin
               state_in = ST_DONE;
            end else begin
               swn_in   = sw;
               fin_in   = fin;
               state_in = ST_FCOM;
            end
         end

         // commit the segment; the previous one leaves for the output
         ST_FCOM: begin
            if (fcom_go) begin
               swnd_in     = swn_ff - 32'(fin_ff);
               next_in     = alu_res;
               avail_in    = avail_ff - 16'(len_ff);
               fin_sent_in = fin_sent_ff || fin_ff;
               mem_we      = 1'b1;
               cnt_in      = cnt_ff + 1'b1;
               if (!run_ff) begin
                  run_in  = 1'b1;
                  elap_in = '0;
               end
               if (pend_v_ff) begin
                  rsp_valid_in            = 1'b1;
                  rsp_in                  = pend_ff;
                  rsp_in.retransmit_count = rcnt_ff;
                  rsp_in.last_result      = 1'b0;
               end
               pend_in.result_kind      = RES_NEW;
               pend_in.segment_seqno    = seq_ff;
               pend_in.payload_length   = 11'(len_ff);
               pend_in.syn_flag         = syn_ff;
               pend_in.fin_flag         = fin_ff;
               pend_in.retransmit_count = '0;
               pend_in.last_result      = 1'b0;
               pend_v_in                = 1'b1;
               k_in                     = k_ff + 1'b1;
               state_in                 = last_chunk_ff ? ST_DONE : ST_FCHK;
            end
         end

         // unwrap: offset from ISN, candidate in next's 2^32 block
         ST_UW1: begin
            c_in     = {next_ff[63:32], alu_res[31:0]};
            state_in = ST_UW2;
         end

         // pick neighbor block if candidate is more than half a span away
         ST_UW2: begin
            gtc        = !alu_borrow && (t != '0);
            adj_dec_in = gtc && t[31] && (t[30:0] != '0) && (c_ff[63:32] != '0);
            adj_inc_in = !gtc && !t[31] && (t[31:0] != '0) && (c_ff[63:32] != '1);
            state_in   = ST_UW3;
         end

         ST_UW3: begin
            if (uw_src_ff) begin
               start_in = alu_res;
               state_in = ST_PEND;
            end else begin
               ackabs_in = alu_res;
               state_in  = ST_ACMP;
            end
         end

         // ack beyond next seqno is dropped
         ST_ACMP: begin
            if (alu_borrow) begin
               state_in = ST_DONE;
            end else begin
               d_in     = alu_res;
               state_in = ST_AWIN;
            end
         end

         ST_AWIN: begin
            swnd_in = alu_borrow ? '0 : alu_res[31:0];
            rwnd_in = advw_ff;
            if (cnt_ff == '0) begin
               cto_in   = 32'(init_to_ff);
               elap_in  = '0;
               run_in   = 1'b0;
               rcnt_in  = '0;
               state_in = ST_DONE;
            end else begin
               popped_in = 1'b0;
               uw_src_in = 1'b1;
               state_in  = ST_PRD;
            end
         end

         // queue head read settles
         ST_PRD: begin
            state_in = ST_UW1;
         end

         ST_PEND: begin
            start_in = alu_res;
            state_in = ST_PCMP;
         end

         ST_PCMP: begin
            if (alu_borrow) begin
               if (popped_ff) begin
                  cto_in  = 32'(init_to_ff);
                  elap_in = '0;
                  run_in  = (cnt_ff != '0);
                  rcnt_in = '0;
               end
               state_in = ST_DONE;
            end else begin
               head_in   = head_nx;
               cnt_in    = cnt_ff - 1'b1;
               popped_in = 1'b1;
               if (cnt_ff == CNT_W'(1)) begin
                  cto_in   = 32'(init_to_ff);
                  elap_in  = '0;
                  run_in   = 1'b0;
                  rcnt_in  = '0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_PRD;
               end
            end
         end

         ST_TADD: begin
            elap_in  = alu_res[32] ? '1 : alu_res[31:0];
            state_in = ST_TCMP;
         end

         ST_TCMP: begin
            if (alu_borrow) begin
               state_in = ST_DONE;
            end else if (cnt_ff == '0) begin
               run_in   = 1'b0;
               elap_in  = '0;
               state_in = ST_DONE;
            end else begin
               state_in = ST_TRD;
            end
         end

         // backoff only while the receiver window is open
         ST_TRD: begin
            if (rwnd_ff != '0) begin
               if (rcnt_ff != '1) begin
                  rcnt_in = rcnt_ff + 1'b1;
               end
               cto_in = cto_ff[31] ? '1 : {cto_ff[30:0], 1'b0};
            end
            elap_in  = '0;
            state_in = ST_TRTX;
         end

         ST_TRTX: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_in.result_kind      = RES_RETX;
               rsp_in.segment_seqno    = rd_seq;
               rsp_in.payload_length   = 11'(rd_len);
               rsp_in.syn_flag         = rd_syn;
               rsp_in.fin_flag         = rd_fin;
               rsp_in.retransmit_count = rcnt_ff;
               rsp_in.last_result      = 1'b1;
               state_in                = ST_IDLE;
            end
         end

         // final result: held segment, or a bare seqno report
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (pend_v_ff) begin
                  rsp_in    = pend_ff;
                  pend_v_in = 1'b0;
               end else begin
                  rsp_in.result_kind    = (kind_ff == KIND_EMPTY) ? RES_EMPTY : RES_NONE;
                  rsp_in.segment_seqno  = alu_res[31:0];
                  rsp_in.payload_length = '0;
                  rsp_in.syn_flag       = 1'b0;
                  rsp_in.fin_flag       = 1'b0;
               end
               rsp_in.retransmit_count = rcnt_ff;
               rsp_in.last_result      = 1'b1;
               state_in                = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         isn_ff       <= '0;
         init_to_ff   <= TIMEOUT_RESET;
         next_ff      <= '0;
         swnd_ff      <= 32'd1;
         rwnd_ff      <= 16'd1;
         fin_sent_ff  <= 1'b0;
         head_ff      <= '0;
         cnt_ff       <= '0;
         run_ff       <= 1'b0;
         elap_ff      <= '0;
         cto_ff       <= 32'(TIMEOUT_RESET);
         rcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         pend_v_ff    <= 1'b0;
         k_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         isn_ff       <= isn_in;
         init_to_ff   <= init_to_in;
         next_ff      <= next_in;
         swnd_ff      <= swnd_in;
         rwnd_ff      <= rwnd_in;
         fin_sent_ff  <= fin_sent_in;
         head_ff      <= head_in;
         cnt_ff       <= cnt_in;
         run_ff       <= run_in;
         elap_ff      <= elap_in;
         cto_ff       <= cto_in;
         rcnt_ff      <= rcnt_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_v_ff    <= pend_v_in;
         k_ff         <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      avail_ff      <= avail_in;
      ended_ff      <= ended_in;
      ackn_ff       <= ackn_in;
      advw_ff       <= advw_in;
      ms_ff         <= ms_in;
      rem_ff        <= rem_in;
      chunk_ff      <= chunk_in;
      last_chunk_ff <= last_chunk_in;
      syn_ff        <= syn_in;
      len_ff        <= len_in;
      seq_ff        <= seq_in;
      swn_ff        <= swn_in;
      fin_ff        <= fin_in;
      popped_ff     <= popped_in;
      uw_src_ff     <= uw_src_in;
      c_ff          <= c_in;
      adj_inc_ff    <= adj_inc_in;
      adj_dec_ff    <= adj_dec_in;
      ackabs_ff     <= ackabs_in;
      d_ff          <= d_in;
      start_ff      <= start_in;
      pend_ff       <= pend_in;
      rsp_ff        <= rsp_in;
   end

   // flight queue: write at tail, head read registered every cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[tail] <= mem_wdata;
      end
      rd_ff <= mem[head_ff];
   end

   `TSW_ASSERT(a_cnt_range, cnt_ff <= CNT_W'(FLIGHT_DEPTH), "flight count above depth")
   `TSW_ASSERT(a_fin_sticky, fin_sent_ff |=> fin_sent_ff, "fin_sent cleared outside reset")
   `TSW_ASSERT_IMP(a_idle_no_pend, state_ff == ST_IDLE, !pend_v_ff, "held segment left at idle")
   `TSW_ASSERT(a_push_timer, (state_ff == ST_FCOM && fcom_go) |=> (cnt_ff != '0 && run_ff), "push w/o timer")
   `TSW_ASSERT(a_seg_limit, k_ff <= K_W'(MAX_RESULTS), "segment count over limit")

endmodule

[test/tb_tcp_sender_window_retransmit.sv]
module tb_tcp_sender_window_retransmit;
   import tsw_pkg::*;

   // Reference copy of the sender: sequence space, windows, flight FIFO and
   // retransmission timer. Accepted requests go in through note_req; the
   // segment descriptors they should produce wait in seg_expected.
   class seg_scoreboard;
      bit [31:0] isn;
      bit [31:0] rto_init;
      bit [63:0] next_abs;
      bit [31:0] snd_win;
      bit [31:0] rcv_win;
      bit        fin_done;
      bit [31:0] fq_seq [FLIGHT_DEPTH_DEF];
      bit [31:0] fq_len [FLIGHT_DEPTH_DEF];
      bit        fq_syn [FLIGHT_DEPTH_DEF];
      bit        fq_fin [FLIGHT_DEPTH_DEF];
      int        fq_head;
      int        fq_count;
      bit        tmr_on;
      bit [31:0] tmr_el;
      bit [31:0] rto;
      bit [7:0]  retx_cnt;
      // per-fill scratch
      bit [31:0] avail;
      bit        ended;
      rsp_type   burst[$];
      rsp_type   seg_expected[$];
      int        errors;
      int        n_req;
      int        n_checked;
      int        n_new;
      int        n_retx;

      function new();
         isn = 0;
         rto_init = 32'(TIMEOUT_RESET);
         next_abs = 0;
         snd_win = 1;
         rcv_win = 1;
         fin_done = 0;
         fq_head = 0;
         fq_count = 0;
         tmr_on = 0;
         tmr_el = 0;
         rto = 32'(TIMEOUT_RESET);
         retx_cnt = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
         if (idx == CSR_ISN) begin
            isn = d;
         end else begin
            rto_init = 32'(d[15:0]);
            rto = rto_init;
         end
      endfunction

      function bit [31:0] wrap_seq(bit [63:0] a);
         return a[31:0] + isn;
      endfunction

      // nearest absolute value to cp; ties stay in cp's 2^32 block
      function bit [63:0] unwrap_seq(bit [31:0] n, bit [63:0] cp);
         bit [31:0] o;
         bit [63:0] c;
         o = n - isn;
         c = {cp[63:32], o};
         if (c > cp) begin
            if (c - cp > 64'h8000_0000 && c >= 64'h1_0000_0000) c -= 64'h1_0000_0000;
         end else begin
            if (cp - c > 64'h8000_0000 && c <= 64'hFFFF_FFFE_FFFF_FFFF)
               c += 64'h1_0000_0000;
         end
         return c;
      endfunction

      function void add_seg(res_kind_type k, bit [31:0] s, bit [31:0] l, bit sy, bit fi);
         rsp_type e;
         e.result_kind = k;
         e.segment_seqno = s;
         e.payload_length = l[10:0];
         e.syn_flag = sy;
         e.fin_flag = fi;
         e.retransmit_count = 0;
         e.last_result = 0;
         burst.insert(burst.size(), e);
      endfunction

      function void reset_timer(bit run);
         rto = rto_init;
         tmr_el = 0;
         tmr_on = run;
         retx_cnt = 0;
      endfunction

      function void cut_segment(bit [31:0] win);
         bit        sy;
         bit        fi;
         bit [31:0] l;
         bit [31:0] sw;
         bit [31:0] s;
         int        slot;
         sy = 0;
         fi = 0;
         l = 0;
         if (win == 0 || fin_done || fq_count >= FLIGHT_DEPTH_DEF ||
             burst.size() >= MAX_RESULTS) return;
         s = wrap_seq(next_abs);
         if (next_abs == 0) begin
            sy = 1;
         end else begin
            if (avail == 0 && !ended) return;
            l = (win < avail) ? win : avail;
         end
         sw = snd_win;
         sw = (sw > sy) ? sw - sy : 0;
         sw = (sw > l) ? sw - l : 0;
         if (ended && avail == l && sw > 0) fi = 1;
         if (sy + l + fi == 0) return;
         snd_win = sw - fi;
         next_abs += sy + l + fi;
         avail -= l;
         if (fi) fin_done = 1;
         slot = (fq_head + fq_count) % FLIGHT_DEPTH_DEF;
         fq_seq[slot] = s;
         fq_len[slot] = l;
         fq_syn[slot] = sy;
         fq_fin[slot] = fi;
         fq_count++;
         if (!tmr_on) begin
            tmr_on = 1;
            tmr_el = 0;
         end
         add_seg(RES_NEW, s, l, sy, fi);
         n_new++;
      endfunction

      function void do_fill();
         bit [31:0] rem;
         bit [31:0] step;
         if (snd_win <= MAX_PAYLOAD_DEF) begin
            cut_segment(snd_win);
         end else begin
            rem = snd_win;
            while (rem > MAX_PAYLOAD_DEF) begin
               step = MAX_PAYLOAD_DEF;
               if (next_abs == 0) step += 1;
               cut_segment(step);
               rem -= step;
            end
            if (rem != 0) cut_segment(rem);
         end
      endfunction

      function void do_ack(bit [31:0] ackno, bit [15:0] win);
         bit [63:0] a;
         bit [63:0] d;
         bit [63:0] base;
         bit [63:0] st;
         bit [63:0] fin_end;
         bit        popped;
         popped = 0;
         a = unwrap_seq(ackno, next_abs);
         if (a > next_abs) return;   // acks unsent data: ignored
         rcv_win = 32'(win);
         d = next_abs - a;
         base = 64'(win) + 64'(win == 0);
         snd_win = (d < base) ? 32'(base - d) : 0;
         if (fq_count == 0) begin
            reset_timer(0);
            return;
         end
         while (fq_count > 0) begin
            st = unwrap_seq(fq_seq[fq_head], next_abs);
            fin_end = st + fq_syn[fq_head] + fq_len[fq_head] + fq_fin[fq_head];
            if (a < fin_end) break;
            fq_head = (fq_head + 1) % FLIGHT_DEPTH_DEF;
            fq_count--;
            popped = 1;
         end
         if (popped) reset_timer(fq_count > 0);
      endfunction

      function void do_tick(bit [15:0] ms);
         if (!tmr_on) return;
         tmr_el = (tmr_el > 32'hFFFF_FFFF - ms) ? 32'hFFFF_FFFF : tmr_el + ms;
         if (tmr_el < rto) return;
         if (fq_count == 0) begin
            tmr_on = 0;
            tmr_el = 0;
            return;
         end
         add_seg(RES_RETX, fq_seq[fq_head], fq_len[fq_head], fq_syn[fq_head],
                 fq_fin[fq_head]);
         n_retx++;
         // zero window probes do not back off
         if (rcv_win != 0) begin
            if (retx_cnt != 8'hFF) retx_cnt++;
            rto = (rto > 32'h7FFF_FFFF) ? 32'hFFFF_FFFF : rto * 2;
         end
         tmr_el = 0;
      endfunction

      function void note_req(req_type r);
         burst.delete();
         n_req++;
         case (r.kind)
            KIND_FILL: begin
               avail = 32'(r.buffered_bytes);
               ended = r.input_ended;
               do_fill();
            end
            KIND_ACK:  do_ack(r.ack_number, r.advertised_window);
            KIND_TICK: do_tick(r.elapsed_ms);
            default:   add_seg(RES_EMPTY, wrap_seq(next_abs), 0, 0, 0);
         endcase
         if (burst.size() == 0) add_seg(RES_NONE, wrap_seq(next_abs), 0, 0, 0);
         foreach (burst[i]) begin
            burst[i].retransmit_count = retx_cnt;
            burst[i].last_result = (i == burst.size() - 1);
            seg_expected.insert(seg_expected.size(), burst[i]);
         end
      endfunction

      function void check_rsp(rsp_type a);
         rsp_type e;
         if (seg_expected.size() == 0) begin
            $error("unexpected result item kind=%0d seqno=%h", a.result_kind,
                   a.segment_seqno);
            errors++;
            return;
         end
         e = seg_expected[0];
         seg_expected.delete(0);
         n_checked++;
         if (a.result_kind !== e.result_kind) begin
            $error("result_kind exp %0d got %0d", e.result_kind, a.result_kind);
            errors++;
         end
         if (a.segment_seqno !== e.segment_seqno) begin
            $error("segment_seqno exp %h got %h", e.segment_seqno, a.segment_seqno);
            errors++;
         end
         if (a.payload_length !== e.payload_length) begin
            $error("payload_length exp %0d got %0d", e.payload_length, a.payload_length);
            errors++;
         end
         if (a.syn_flag !== e.syn_flag) begin
            $error("syn_flag exp %0d got %0d", e.syn_flag, a.syn_flag);
            errors++;
         end
         if (a.fin_flag !== e.fin_flag) begin
            $error("fin_flag exp %0d got %0d", e.fin_flag, a.fin_flag);
            errors++;
         end
         if (a.retransmit_count !== e.retransmit_count) begin
            $error("retransmit_count exp %0d got %0d", e.retransmit_count,
                   a.retransmit_count);
            errors++;
         end
         if (a.last_result !== e.last_result) begin
            $error("last_result exp %0d got %0d", e.last_result, a.last_result);
            errors++;
         end
      endfunction
   endclass

   localparam int STALL_LIMIT = 20000;   // cycles with no item moving
   localparam int HOLD_CYCLES = 400;     // long receiver stall
   localparam int DRAIN_WAIT  = 50;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   tsw_chan_if #(.payload_type(req_type)) req_if ();
   tsw_chan_if #(.payload_type(rsp_type)) rsp_if ();

   tcp_sender_window_retransmit uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   seg_scoreboard sb = new();
   bit no_idle = 0;      // both sides stream flat out while set
   bit allow_end = 0;    // stream may close (FIN) only late in the run

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Receiver: random ready, one long hold-off once the run is under way.
   // ---------------------------------------------------------------------
   initial begin : rx_side
      int hold_left;
      bit held;
      hold_left = 0;
      held = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid && rsp_if.ready) sb.check_rsp(rsp_if.payload);
         if (!held && sb.n_req >= 160) begin
            held = 1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 15);
         end
      end
   end

   // Watchdog: any handshake on either channel restarts the count.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet = 0;
         else
            quiet++;
         if (quiet >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Sender side
   // ---------------------------------------------------------------------
   // valid is only dropped for an idle gap, so back-to-back items never see
   // two assignments to it in one step.
   task automatic send_item(req_type r);
      int gap;
      if (!no_idle && $urandom_range(0, 99) < 15) begin
         req_if.valid <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.payload <= r;
      do @(posedge clock); while (!req_if.ready);
      sb.note_req(r);
   endtask

   // Quiet the input and let every expected result come home, plus margin
   // for anything the sequencer still has in work.
   task automatic settle();
      req_if.valid <= 1'b0;
      while (sb.seg_expected.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // One write per call; the trailing wait with csr_we low keeps back-to-back writes apart.
   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] d);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.write_reg(idx, d);
      @(posedge clock);
   endtask

   // Unused fields get random bits so every input bit toggles.
   function automatic req_type rnd_base(req_kind_type k);
      req_type r;
      r.kind = k;
      r.buffered_bytes = 16'($urandom);
      r.input_ended = 1'($urandom);
      r.ack_number = $urandom;
      r.advertised_window = 16'($urandom);
      r.elapsed_ms = 16'($urandom);
      return r;
   endfunction

   function automatic req_type mk_fill(int bytes, bit ended);
      req_type r;
      r = rnd_base(KIND_FILL);
      r.buffered_bytes = 16'(bytes);
      r.input_ended = ended;
      return r;
   endfunction

   // ack of absolute position next_abs - back
   function automatic req_type mk_ack(int back, int win);
      req_type r;
      r = rnd_base(KIND_ACK);
      r.ack_number = sb.wrap_seq(sb.next_abs - 64'(back));
      r.advertised_window = 16'(win);
      return r;
   endfunction

   function automatic req_type mk_tick(int ms);
      req_type r;
      r = rnd_base(KIND_TICK);
      r.elapsed_ms = 16'(ms);
      return r;
   endfunction

   function automatic req_type rnd_item();
      req_type r;
      int sel;
      int lim;
      sel = $urandom_range(0, 99);
      if (sel < 35) begin
         r = mk_fill(($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                 : $urandom_range(0, 3000),
                     allow_end && $urandom_range(0, 29) == 0);
      end else if (sel < 70) begin
         if ($urandom_range(0, 99) < 85) begin
            // mostly acks inside the sent range, a few with zero window
            lim = (sb.next_abs > 3000) ? 3000 : int'(sb.next_abs);
            r = mk_ack($urandom_range(0, lim),
                       ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(0, 65535));
         end else begin
            r = rnd_base(KIND_ACK);   // noise: mostly ignored as future acks
         end
      end else if (sel < 90) begin
         r = mk_tick(($urandom_range(0, 99) < 70) ? $urandom_range(0, 2000)
                                                 : $urandom_range(0, 65535));
      end else begin
         r = rnd_base(KIND_EMPTY);
      end
      return r;
   endfunction

   initial begin : main
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_data = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ISN just below the wrap point so sequence numbers roll over early
      write_csr(CSR_ISN, 32'hFFFF_FFF0);
      write_csr(CSR_TIMEOUT, 500);

      // directed opening
      send_item(rnd_base(KIND_EMPTY));
      send_item(mk_tick(65535));               // timer not running: nothing
      send_item(mk_fill(0, 0));                // SYN only, empty stream
      send_item(mk_fill(0, 0));                // window used up
      send_item(mk_ack(-5, 100));              // acks beyond next: ignored
      send_item(mk_tick(499));                 // just short of expiry
      send_item(mk_tick(1));                   // expiry: SYN resent, backoff
      send_item(mk_ack(0, 0));                 // SYN acked, zero window
      send_item(mk_fill(100, 0));              // one-byte probe
      send_item(mk_tick(65535));               // expiry at zero window: no backoff
      send_item(mk_ack(0, 65535));             // max window
      send_item(mk_fill(65535, 0));            // many segments until flight FIFO full
      send_item(mk_fill(65535, 0));            // FIFO still full
      send_item(mk_tick(65535));
      send_item(mk_tick(65535));
      send_item(mk_ack(20000, 65535));         // pop part of the flight
      send_item(mk_fill(3000, 0));
      send_item(mk_ack(0, 0));                 // everything acked
      send_item(mk_tick(0));
      send_item(mk_ack(0, 65535));
      send_item(mk_fill(65535, 0));            // more segments than the flight FIFO holds
      send_item(rnd_base(KIND_EMPTY));
      settle();

      // three settings, extremes included; the stream may close in the last
      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               write_csr(CSR_ISN, 32'hFFFF_FFFF);
               write_csr(CSR_TIMEOUT, 1);
            end
            1: begin
               write_csr(CSR_ISN, 32'h0000_0000);
               write_csr(CSR_TIMEOUT, 32'h0000_FFFF);
            end
            default: begin
               write_csr(CSR_ISN, $urandom);
               write_csr(CSR_TIMEOUT, $urandom_range(200, 3000));
               allow_end = 1;
            end
         endcase
         for (int i = 0; i < 100; i++) begin
            no_idle = (ph == 1 && i >= 20 && i < 80);
            send_item(rnd_item());
         end
         no_idle = 0;
         if (ph == 2) send_item(mk_ack(0, 65535));
         if (ph == 2) send_item(mk_fill(500, 1));   // close the stream: FIN
         if (ph == 2) send_item(mk_fill(500, 1));   // after FIN nothing is sent
         settle();
      end

      $display("run: %0d request items, %0d result items checked", sb.n_req, sb.n_checked);
      $display("     %0d new segments, %0d retransmissions, %0d mismatches",
               sb.n_new, sb.n_retx, sb.errors);
      if (sb.errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
